/* sv/cyclic_word_canonicalizer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Cyclic word canonicalizer: assertion macros
// Shared concurrent assertion forms used by the canonicalizer RTL.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_WORD_CANONICALIZER_UNIT_MACROS_SVH
`define CYCLIC_WORD_CANONICALIZER_UNIT_MACROS_SVH

// Implication check: whenever ante holds, prop must follow.
`define CWC_ASSERT_IMP(lbl, clk, rst_n, ante, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> prop) \
        else $error(msg);

// Forbidden condition: cond must never hold outside reset.
`define CWC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* sv/cwc_pkg.sv */
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared constants and types of the cyclic word canonicalizer.
// ----------------------------------------------------------------------------
package cwc_pkg;

    // Default letter capacity of one word.
    localparam int MAX_LETTERS_DEF = 13;
    // Shortest word the datapath handles; shorter settings are lifted to it.
    localparam int MIN_LETTERS     = 2;
    // Width of the word length register.
    localparam int CFG_W           = 4;
    // Word length after reset.
    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(2);

    // Per-beat control that travels down the pipeline with the data.
    typedef struct packed {
        logic vld;
        logic red;
    } t_ctl;

endpackage

/* sv/cwc_prep.sv */
// ----------------------------------------------------------------------------
// cwc_prep
// Front stages: clamp length, mask the word, then build its inverse and
// the cyclic reduction flag.
// ----------------------------------------------------------------------------
module cwc_prep import cwc_pkg::*; #(
    parameter  int MAX_LETTERS = MAX_LETTERS_DEF,
    localparam int W           = 2 * MAX_LETTERS,
    localparam int NW          = $clog2(MAX_LETTERS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [W-1:0]     i_word,
    input  logic [CFG_W-1:0] i_cfg_len,
    output t_ctl             o_ctl,
    output logic [W-1:0]     o_word,
    output logic [W-1:0]     o_inv,
    output logic [W-1:0]     o_mask,
    output logic [NW-1:0]    o_len
);

    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    // stage 1
    logic [CW-1:0] len_ext;
    logic [NW-1:0] n_len;
    logic [W-1:0]  n_mask;
    logic          r_s1_vld;
    logic [W-1:0]  r_s1_word;
    logic [W-1:0]  r_s1_mask;
    logic [NW-1:0] r_s1_len;

    // stage 2
    logic [W-1:0]  n_inv;
    logic          n_red;
    t_ctl          r_s2_ctl;
    logic [W-1:0]  r_s2_word;
    logic [W-1:0]  r_s2_inv;
    logic [W-1:0]  r_s2_mask;
    logic [NW-1:0] r_s2_len;

    always_comb begin
        len_ext = CW'(i_cfg_len);
        priority if (len_ext < CW'(MIN_LETTERS)) begin
            n_len = NW'(MIN_LETTERS);
        end else if (len_ext > CW'(MAX_LETTERS)) begin
            n_len = NW'(MAX_LETTERS);
        end else begin
            n_len = NW'(len_ext);
        end
        for (int i = 0; i < MAX_LETTERS; i++) begin
            n_mask[2*i +: 2] = (NW'(i) < n_len) ? 2'b11 : 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
        r_s1_word <= i_word & n_mask;
        r_s1_mask <= n_mask;
        r_s1_len  <= n_len;
    end

    // Inverse: letter i takes letter n-1-i with its low bit flipped.
    always_comb begin
        n_inv = '0;
        for (int i = 0; i < MAX_LETTERS; i++) begin
            for (int j = 0; j < MAX_LETTERS; j++) begin
                if ((NW+1)'(i + j + 1) == {1'b0, r_s1_len}) begin
                    n_inv[2*i +: 2] = r_s1_word[2*j +: 2] ^ 2'b01;
                end
            end
        end
    end

    // Reduction: no letter may be followed, cyclically, by its inverse.
    always_comb begin
        logic [1:0] cur;
        logic [1:0] nxt;
        int         nidx;
        n_red = 1'b1;
        for (int i = 0; i < MAX_LETTERS; i++) begin
            nidx = (i == MAX_LETTERS - 1) ? 0 : i + 1;
            cur  = r_s1_word[2*i +: 2];
            nxt  = (NW'(i + 1) == r_s1_len) ? r_s1_word[1:0] : r_s1_word[2*nidx +: 2];
            if ((NW'(i) < r_s1_len) && (nxt == (cur ^ 2'b01))) begin
                n_red = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl.vld <= r_s1_vld;
            r_s2_ctl.red <= n_red;
        end
        r_s2_word <= r_s1_word;
        r_s2_inv  <= n_inv;
        r_s2_mask <= r_s1_mask;
        r_s2_len  <= r_s1_len;
    end

    assign o_ctl  = r_s2_ctl;
    assign o_word = r_s2_word;
    assign o_inv  = r_s2_inv;
    assign o_mask = r_s2_mask;
    assign o_len  = r_s2_len;

endmodule

/* sv/cwc_rot_min.sv */
// ----------------------------------------------------------------------------
// cwc_rot_min
// Rotation stage and a registered minimum tree, one level per stage.
// ----------------------------------------------------------------------------
module cwc_rot_min import cwc_pkg::*; #(
    parameter  int MAX_LETTERS = MAX_LETTERS_DEF,
    localparam int W           = 2 * MAX_LETTERS,
    localparam int NW          = $clog2(MAX_LETTERS + 1),
    localparam int LV          = $clog2(MAX_LETTERS),
    localparam int LEAVES      = 1 << LV
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [W-1:0]  i_word,
    input  logic [W-1:0]  i_inv,
    input  logic [W-1:0]  i_mask,
    input  logic [NW-1:0] i_len,
    output t_ctl          o_ctl,
    output logic [W-1:0]  o_min,
    output logic [W-1:0]  o_word
);

    logic [W-1:0] n_cand [LEAVES];
    // Heap layout: node 0 is the root, leaves start at LEAVES-1.
    logic [W-1:0] r_tree [2*LEAVES-1];
    t_ctl         r_ctl  [LV+1];
    logic [W-1:0] r_word [LV+1];

    // One candidate per rotation amount: smaller of word and inverse rotated.
    always_comb begin
        logic [NW:0]  sh;
        logic [W-1:0] rot_a;
        logic [W-1:0] rot_b;
        for (int r = 0; r < MAX_LETTERS; r++) begin
            sh    = {i_len - NW'(r), 1'b0};
            rot_a = ((i_word >> (2*r)) | (i_word << sh)) & i_mask;
            rot_b = ((i_inv  >> (2*r)) | (i_inv  << sh)) & i_mask;
            if (NW'(r) >= i_len) begin
                rot_a = i_word;
                rot_b = i_inv;
            end
            n_cand[r] = (rot_a < rot_b) ? rot_a : rot_b;
        end
        // Pad the unused leaves with all ones so they never win.
        for (int r = MAX_LETTERS; r < LEAVES; r++) begin
            n_cand[r] = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LEAVES; k++) begin
            r_tree[LEAVES-1+k] <= n_cand[k];
        end
        for (int i = 0; i < LEAVES - 1; i++) begin
            r_tree[i] <= (r_tree[2*i+1] < r_tree[2*i+2]) ? r_tree[2*i+1] : r_tree[2*i+2];
        end
        r_word[0] <= i_word;
        for (int j = 1; j <= LV; j++) begin
            r_word[j] <= r_word[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LV; j++) begin
                r_ctl[j] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int j = 1; j <= LV; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    assign o_ctl  = r_ctl[LV];
    assign o_min  = r_tree[0];
    assign o_word = r_word[LV];

endmodule

/* sv/cyclic_word_canonicalizer_unit.sv */
// ----------------------------------------------------------------------------
// cyclic_word_canonicalizer_unit
// Smallest cyclic rotation of a two-bit-letter word and of its inverse,
// with cyclic reduction and representative flags.
// ----------------------------------------------------------------------------
// Pipeline: clamp and mask, inverse and reduction flag, candidate leaves,
//   then one register per minimum tree level; the minimum tree sets the depth.
// Throughput: one word per cycle; busy never rises and results are never held.
// Reset: synchronous, active low; clears all valid bits, word length reads 2.
// ----------------------------------------------------------------------------
`include "cyclic_word_canonicalizer_unit_macros.svh"

module cyclic_word_canonicalizer_unit import cwc_pkg::*; #(
    parameter  int MAX_LETTERS = MAX_LETTERS_DEF,
    localparam int W           = 2 * MAX_LETTERS,
    localparam int NW          = $clog2(MAX_LETTERS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  logic [W-1:0]     i_word_bits,
    // result channel
    output logic             o_result_strobe,
    output logic [W-1:0]     o_canonical_word,
    output logic             o_cyclically_reduced,
    output logic             o_is_representative,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_word_length
);

    // Cycles from an accepted beat to its result strobe.
    localparam int LAT = 3 + $clog2(MAX_LETTERS);

    logic [CFG_W-1:0] r_word_length;
    logic [CFG_W-1:0] n_word_length;
    logic             accept;

    t_ctl             prep_ctl;
    logic [W-1:0]     prep_word;
    logic [W-1:0]     prep_inv;
    logic [W-1:0]     prep_mask;
    logic [NW-1:0]    prep_len;

    t_ctl             out_ctl;
    logic [W-1:0]     out_min;
    logic [W-1:0]     out_word;

    // The pipeline never stalls, so every command beat is taken at once.
    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Word length register: take the new value on a config beat, else hold.
    always_comb begin
        n_word_length = r_word_length;
        if (i_cfg_valid && o_cfg_ready) begin
            n_word_length = i_cfg_word_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= LEN_RESET;
        end else begin
            r_word_length <= n_word_length;
        end
    end

    // Stages 1-2: clamp the length and mask the word, then form the inverse
    // and check cyclic reduction. The clamped length rides with each beat,
    // so a beat keeps the length it was accepted under.
    cwc_prep #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (accept),
        .i_word    (i_word_bits),
        .i_cfg_len (r_word_length),
        .o_ctl     (prep_ctl),
        .o_word    (prep_word),
        .o_inv     (prep_inv),
        .o_mask    (prep_mask),
        .o_len     (prep_len)
    );

    // Stage 3 onward: all rotations in parallel, pairwise minimum into the
    // leaves, then one tree level per stage down to the root.
    cwc_rot_min #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_rot_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prep_ctl),
        .i_word  (prep_word),
        .i_inv   (prep_inv),
        .i_mask  (prep_mask),
        .i_len   (prep_len),
        .o_ctl   (out_ctl),
        .o_min   (out_min),
        .o_word  (out_word)
    );

    // Drive the result beat straight off the tree root registers.
    assign o_result_strobe      = out_ctl.vld;
    assign o_canonical_word     = out_min;
    assign o_cyclically_reduced = out_ctl.red;
    // A reduced word that is already its own minimum is the representative.
    assign o_is_representative  = out_ctl.red && (out_min == out_word);

    // Every accepted beat surfaces as a result strobe.
    `CWC_ASSERT_IMP(a_lat_fwd, i_clk, i_rst_n, accept, ##LAT o_result_strobe, "result beat missing")
    // No result beat without a matching earlier command beat.
    `CWC_ASSERT_IMP(a_lat_bwd, i_clk, i_rst_n, o_result_strobe, $past(accept, LAT), "spurious result")
    // The word itself is one of the candidates, so the minimum cannot exceed it.
    `CWC_ASSERT_NEVER(a_min_bound, i_clk, i_rst_n, o_result_strobe && (out_word < out_min), "min above word")

endmodule

/* sim/cwc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_checker
// Watches the command, result and length-write channels of the cyclic word
// canonicalizer, predicts each result from its own copy of the word length
// and compares every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

package cwc_tb_pkg;

    localparam int WORD_W = 2 * cwc_pkg::MAX_LETTERS_DEF;

    // Letters in use for a length register value, clamped to 2..MAX.
    function automatic int unsigned letter_count(logic [cwc_pkg::CFG_W-1:0] len);
        int unsigned n;
        n = len;
        if (n < cwc_pkg::MIN_LETTERS) n = cwc_pkg::MIN_LETTERS;
        if (n > cwc_pkg::MAX_LETTERS_DEF) n = cwc_pkg::MAX_LETTERS_DEF;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] live_mask(int unsigned n);
        logic [63:0] m;
        m = (64'd1 << (2 * n)) - 64'd1;
        return m[WORD_W-1:0];
    endfunction

    // Smallest rotation of the word and of its inverse.
    function automatic logic [WORD_W-1:0] orbit_minimum(logic [WORD_W-1:0] w,
                                                         int unsigned n);
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] best;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [1:0]        letter;
        m    = live_mask(n);
        w    = w & m;
        inv  = '0;
        for (int unsigned i = 0; i < n; i++) begin
            letter = w[2*i +: 2] ^ 2'd1;
            inv[2*(n-1-i) +: 2] = letter;
        end
        best = w;
        for (int unsigned r = 0; r < n; r++) begin
            if (r == 0) begin
                a = w;
                b = inv;
            end else begin
                a = ((w >> (2 * r)) | (w << (2 * (n - r)))) & m;
                b = ((inv >> (2 * r)) | (inv << (2 * (n - r)))) & m;
            end
            if (a < best) best = a;
            if (b < best) best = b;
        end
        return best;
    endfunction

    // No letter followed cyclically by its own inverse.
    function automatic logic word_is_reduced(logic [WORD_W-1:0] w, int unsigned n);
        int unsigned j;
        for (int unsigned i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (w[2*j +: 2] == (w[2*i +: 2] ^ 2'd1)) return 1'b0;
        end
        return 1'b1;
    endfunction

endpackage

module cwc_checker import cwc_pkg::*; import cwc_tb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [WORD_W-1:0] i_word_bits,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_word_length,
    input  logic              i_result_strobe,
    input  logic [WORD_W-1:0] i_canonical_word,
    input  logic              i_cyclically_reduced,
    input  logic              i_is_representative,
    output int                o_failures,
    output int                o_pending,
    output int                o_checked,
    output int                o_reduced_seen,
    output int                o_reps_seen
);

    typedef struct {
        logic [WORD_W-1:0] canon;
        logic              reduced;
        logic              rep;
    } t_canon_result;

    t_canon_result    canon_queue[$];
    logic [CFG_W-1:0] length_shadow;
    int               failures;
    int               checked;
    int               reduced_seen;
    int               reps_seen;

    assign o_failures     = failures;
    assign o_checked      = checked;
    assign o_reduced_seen = reduced_seen;
    assign o_reps_seen    = reps_seen;

    initial begin
        failures     = 0;
        checked      = 0;
        reduced_seen = 0;
        reps_seen    = 0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%07h, expected 0x%07h", $time, what, got, want);
        failures++;
    endtask

    always @(posedge i_clk) begin
        t_canon_result     head;
        t_canon_result     next;
        int unsigned       n;
        logic [WORD_W-1:0] w;
        if (!i_rst_n) begin
            length_shadow = LEN_RESET;
            canon_queue.delete();
        end else begin
            if (i_result_strobe) begin
                if (canon_queue.size() == 0) begin
                    report_mismatch("unexpected result", i_canonical_word, '0);
                end else begin
                    head = canon_queue.pop_front();
                    checked++;
                    if (i_canonical_word !== head.canon)
                        report_mismatch("canonical_word", i_canonical_word, head.canon);
                    if (i_cyclically_reduced !== head.reduced)
                        report_mismatch("cyclically_reduced",
                                        WORD_W'(i_cyclically_reduced), WORD_W'(head.reduced));
                    if (i_is_representative !== head.rep)
                        report_mismatch("is_representative",
                                        WORD_W'(i_is_representative), WORD_W'(head.rep));
                    if (head.reduced) reduced_seen++;
                    if (head.rep) reps_seen++;
                end
            end
            // A command beat on the same edge as a length write uses the old length.
            if (i_start && !i_busy) begin
                n            = letter_count(length_shadow);
                w            = i_word_bits & live_mask(n);
                next.canon   = orbit_minimum(w, n);
                next.reduced = word_is_reduced(w, n);
                next.rep     = next.reduced && (next.canon == w);
                canon_queue.push_back(next);
            end
            if (i_cfg_valid && i_cfg_ready) length_shadow = i_cfg_word_length;
        end
        o_pending = canon_queue.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the cyclic word canonicalizer with directed and random words over
// every word length setting, pacing the command channel at several idle
// rates; the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------

module testbench;
    import cwc_pkg::*;
    import cwc_tb_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Settle time after the last result.
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PHASES  = 16;
    localparam int WORDS_PER_PHASE = 116;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [WORD_W-1:0] i_word_bits;
    logic              o_result_strobe;
    logic [WORD_W-1:0] o_canonical_word;
    logic              o_cyclically_reduced;
    logic              o_is_representative;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_word_length;

    int failures;
    int pending;
    int checked;
    int reduced_seen;
    int reps_seen;
    int stall_cycles;
    int sender_idle_pct;

    cyclic_word_canonicalizer_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_word_bits          (i_word_bits),
        .o_result_strobe      (o_result_strobe),
        .o_canonical_word     (o_canonical_word),
        .o_cyclically_reduced (o_cyclically_reduced),
        .o_is_representative  (o_is_representative),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_word_length    (i_cfg_word_length)
    );

    cwc_checker u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_word_bits          (i_word_bits),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_word_length    (i_cfg_word_length),
        .i_result_strobe      (o_result_strobe),
        .i_canonical_word     (o_canonical_word),
        .i_cyclically_reduced (o_cyclically_reduced),
        .i_is_representative  (o_is_representative),
        .o_failures           (failures),
        .o_pending            (pending),
        .o_checked            (checked),
        .o_reduced_seen       (reduced_seen),
        .o_reps_seen          (reps_seen)
    );

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no beat anywhere, give up at the limit.
    initial stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no channel activity for %0d cycles", WATCHDOG_LIMIT);
                $display("cyclic_word_canonicalizer_unit verification failed");
                $finish;
            end
        end
    end

    // Hold until every predicted result has come back.
    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the length register; only called with the block drained.
    task automatic write_length(input logic [CFG_W-1:0] len);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_word_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b0;
        i_cfg_word_length <= CFG_W'($urandom);
    endtask

    // Issue one command beat, idling first at the current sender rate.
    // Noise on the word bus during idle cycles must be ignored by the block.
    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start       <= 1'b0;
            i_word_bits <= WORD_W'($urandom);
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_word_bits <= w;
        do @(posedge i_clk); while (busy);
    endtask

    // Random cyclically reduced word over n letters; bits above stay random.
    function automatic logic [WORD_W-1:0] reduced_word(int unsigned n);
        logic [WORD_W-1:0] w;
        logic [1:0]        letter;
        w = WORD_W'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            do begin
                letter = 2'($urandom_range(3));
            end while ((i > 0 && letter == (w[2*(i-1) +: 2] ^ 2'd1)) ||
                       (i == n - 1 && w[1:0] == (letter ^ 2'd1)));
            w[2*i +: 2] = letter;
        end
        return w;
    endfunction

    // Mix: raw random words, reduced words, and orbit representatives.
    function automatic logic [WORD_W-1:0] random_word(int unsigned n);
        logic [WORD_W-1:0] w;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 45) return WORD_W'($urandom);
        w = reduced_word(n);
        if (pick < 85) return w;
        return orbit_minimum(w, n) | (w & ~live_mask(n));
    endfunction

    // Directed words: all a, all b inverse, all a inverse, alternating a b,
    // and a b-run whose only cancellation is across the wraparound.
    logic [WORD_W-1:0] directed_words[5] = '{26'h0000000, 26'h3FFFFFF, 26'h1555555,
                                             26'h0888888, 26'h1AAAAA8};
    // Directed lengths: maximum, zero, one, above maximum, minimum.
    logic [CFG_W-1:0]  directed_lengths[5] = '{4'd13, 4'd0, 4'd1, 4'd15, 4'd2};
    // Random phases sweep every register value, extremes first.
    logic [CFG_W-1:0]  phase_lengths[RANDOM_PHASES] = '{4'd2, 4'd13, 4'd0, 4'd15,
        4'd7, 4'd1, 4'd14, 4'd5, 4'd9, 4'd3, 4'd11, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12};

    initial begin
        int unsigned n;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_word_bits       = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_word_length = '0;
        sender_idle_pct   = 7;

        // Synchronous reset, release on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: first at the reset length, then across the extremes.
        foreach (directed_words[k]) send_word(directed_words[k]);
        foreach (directed_lengths[p]) begin
            @(negedge i_clk);
            start <= 1'b0;
            write_length(directed_lengths[p]);
            for (int k = 0; k < 4; k++) send_word(directed_words[k + (p % 2)]);
        end

        // Random part: sender idles at 7%, then 72%, then not at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            @(negedge i_clk);
            start <= 1'b0;
            write_length(phase_lengths[p]);
            sender_idle_pct = (p < 6) ? 7 : (p < 11) ? 72 : 0;
            n = letter_count(phase_lengths[p]);
            for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_word(n));
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered all 16 length settings at three sender idle rates:");
        $display("%0d results checked, %0d cyclically reduced, %0d representatives",
                 checked, reduced_seen, reps_seen);
        if (failures == 0) begin
            $display("cyclic_word_canonicalizer_unit verification clean");
        end else begin
            $display("cyclic_word_canonicalizer_unit verification failed");
        end
        $finish;
    end

endmodule
